@@ sv/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// Types, sizes and codes shared by the stable min priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KID_W    = IDX_W + 2;

  localparam logic ACT_PUT = 1'b0;
  localparam logic ACT_GET = 1'b1;

  localparam logic [1:0] ST_DELIVERED = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  // pkey is the priority with its sign bit inverted, so that unsigned order
  // of {pkey, stamp} is the service order.
  typedef struct packed {
    logic [31:0] tag;
    logic [31:0] value;
    logic [31:0] pkey;
    logic [31:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

@@ sv/spq_if.sv @@
// ----------------------------------------------------------------------------
// spq_if
// Valid/ready channels for requests into and results out of the queue.
// ----------------------------------------------------------------------------
`default_nettype none

interface spq_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic        [31:0] message_tag;
  logic signed [31:0] message_value;
  logic signed [31:0] priority_req;

  modport source (output valid, action, message_tag, message_value, priority_req,
                  input ready);
  modport sink   (input valid, action, message_tag, message_value, priority_req,
                  output ready);
endinterface

interface spq_out_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  status;
  logic        [31:0] message_tag_res;
  logic signed [31:0] message_value_res;

  modport source (output valid, status, message_tag_res, message_value_res,
                  input ready);
  modport sink   (input valid, status, message_tag_res, message_value_res,
                  output ready);
endinterface

`default_nettype wire

@@ sv/spq_ram.sv @@
// ----------------------------------------------------------------------------
// spq_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ sv/spq_cmp.sv @@
// ----------------------------------------------------------------------------
// spq_cmp
// Shared ordering compare: priority key first, arrival stamp on a tie.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cmp
  import spq_pkg::*;
(
  input  wire entry_t a,
  input  wire entry_t b,
  output logic        a_first
);

  assign a_first = {a.pkey, a.stamp} < {b.pkey, b.stamp};

endmodule

`default_nettype wire

@@ sv/stable_min_priority_queue.sv @@
// ----------------------------------------------------------------------------
// stable_min_priority_queue
// Binary min heap of CAPACITY messages in one RAM, sifted by a sequencer
// around a single compare unit. A put stamps the message with a running
// arrival number and climbs the heap; a get returns the lowest priority,
// earliest arrival first, then sifts the last entry down from the root.
// One request is taken at a time and the request side is not ready while
// it is worked on. A put reads the parent and compares once per level
// climbed, until it reaches the root or stops below it; a get reads the
// root and the last entry, then per level descended reads the left and,
// if present, the right child and compares, ending at a leaf or when the
// last compare keeps the entry in place; a get that empties the store
// skips the sift. The RAM's single read port with registered data and the
// one shared comparator set this sequence. A full put and an empty get go
// straight to the result step. The result step waits while the output
// register still holds a result that has not been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_min_priority_queue
  import spq_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  spq_in_if.sink     cmd,
  spq_out_if.source  rsp
);

  typedef enum logic [3:0] {
    IDLE, UP_CHK, UP_CMP, G_ROOT, G_LAST, DN_CHK, DN_L, DN_R, DN_CMP, EMIT
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [31:0]      arrival;
  logic [IDX_W-1:0] pos;
  logic [IDX_W-1:0] par;
  logic [IDX_W-1:0] cidx;
  entry_t           cur;
  entry_t           child;
  logic [1:0]       res_status;
  logic [31:0]      res_tag;
  logic [31:0]      res_value;
  logic             out_valid;
  logic [1:0]       out_status;
  logic [31:0]      out_tag;
  logic [31:0]      out_value;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           ram_rdata;
  entry_t           cmp_a;
  entry_t           cmp_b;
  logic             a_first;

  logic             cmd_xfer;
  logic             is_full;
  logic [IDX_W-1:0] pos_m1;
  logic [IDX_W-1:0] parent;
  logic [KID_W-1:0] left;
  logic [KID_W-1:0] right;
  logic [KID_W-1:0] count_k;
  logic [CNT_W-1:0] count_dec;
  logic             out_free;

  spq_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  spq_cmp u_cmp (
    .a       (cmp_a),
    .b       (cmp_b),
    .a_first (a_first)
  );

  assign cmd.ready             = (state == IDLE);
  assign cmd_xfer              = cmd.valid && cmd.ready;
  assign is_full               = (count == CNT_W'(CAPACITY));
  assign pos_m1                = pos - IDX_W'(1);
  assign parent                = {1'b0, pos_m1[IDX_W-1:1]};
  assign left                  = {1'b0, pos, 1'b1};
  assign right                 = left + KID_W'(1);
  assign count_k               = {{(KID_W-CNT_W){1'b0}}, count};
  assign count_dec             = count - CNT_W'(1);
  assign out_free              = !out_valid || rsp.ready;

  assign rsp.valid             = out_valid;
  assign rsp.status            = out_status;
  assign rsp.message_tag_res   = out_tag;
  assign rsp.message_value_res = out_value;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos;
    ram_wdata = cur;
    ram_raddr = '0;
    cmp_a     = cur;
    cmp_b     = ram_rdata;
    case (state)
      UP_CHK: begin
        ram_raddr = parent;
        if (pos == '0) begin
          ram_we = 1'b1;
        end
      end
      UP_CMP: begin
        ram_we = 1'b1;
        if (a_first) begin
          ram_wdata = ram_rdata;
        end
      end
      G_ROOT: begin
        ram_raddr = count_dec[IDX_W-1:0];
      end
      DN_CHK: begin
        ram_raddr = left[IDX_W-1:0];
        if (left >= count_k) begin
          ram_we = 1'b1;
        end
      end
      DN_L: begin
        ram_raddr = right[IDX_W-1:0];
      end
      DN_R: begin
        cmp_a = ram_rdata;
        cmp_b = child;
      end
      DN_CMP: begin
        cmp_a  = child;
        cmp_b  = cur;
        ram_we = 1'b1;
        if (a_first) begin
          ram_wdata = child;
        end
      end
      default: begin
        ram_raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      count     <= '0;
      arrival   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && state != EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (cmd_xfer) begin
            if (cmd.action == ACT_PUT) begin
              if (is_full) begin
                res_status <= ST_FULL;
                res_tag    <= '0;
                res_value  <= '0;
                state      <= EMIT;
              end else begin
                cur.tag   <= cmd.message_tag;
                cur.value <= cmd.message_value;
                cur.pkey  <= {~cmd.priority_req[31], cmd.priority_req[30:0]};
                cur.stamp <= arrival;
                arrival   <= arrival + 32'd1;
                pos       <= count[IDX_W-1:0];
                count     <= count + CNT_W'(1);
                state     <= UP_CHK;
              end
            end else begin
              if (count == '0) begin
                res_status <= ST_EMPTY;
                res_tag    <= '0;
                res_value  <= '0;
                state      <= EMIT;
              end else begin
                state <= G_ROOT;
              end
            end
          end
        end
        UP_CHK: begin
          par <= parent;
          if (pos == '0) begin
            state <= IDLE;
          end else begin
            state <= UP_CMP;
          end
        end
        UP_CMP: begin
          if (a_first) begin
            pos   <= par;
            state <= UP_CHK;
          end else begin
            state <= IDLE;
          end
        end
        G_ROOT: begin
          res_status <= ST_DELIVERED;
          res_tag    <= ram_rdata.tag;
          res_value  <= ram_rdata.value;
          count      <= count_dec;
          if (count_dec == '0) begin
            state <= EMIT;
          end else begin
            state <= G_LAST;
          end
        end
        G_LAST: begin
          cur   <= ram_rdata;
          pos   <= '0;
          state <= DN_CHK;
        end
        DN_CHK: begin
          if (left >= count_k) begin
            state <= EMIT;
          end else begin
            state <= DN_L;
          end
        end
        DN_L: begin
          child <= ram_rdata;
          cidx  <= left[IDX_W-1:0];
          if (right < count_k) begin
            state <= DN_R;
          end else begin
            state <= DN_CMP;
          end
        end
        DN_R: begin
          if (a_first) begin
            child <= ram_rdata;
            cidx  <= right[IDX_W-1:0];
          end
          state <= DN_CMP;
        end
        DN_CMP: begin
          if (a_first) begin
            pos   <= cidx;
            state <= DN_CHK;
          end else begin
            state <= EMIT;
          end
        end
        EMIT: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_tag    <= res_tag;
            out_value  <= res_value;
            state      <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_full_put: assert property (@(posedge clk) disable iff (rst)
    cmd_xfer && cmd.action == ACT_PUT && is_full |=>
      state == EMIT && res_status == ST_FULL && $stable(count) && $stable(arrival))
    else $error("full put not reported or state changed");

  a_empty_get: assert property (@(posedge clk) disable iff (rst)
    cmd_xfer && cmd.action == ACT_GET && count == '0 |=>
      state == EMIT && res_status == ST_EMPTY && count == '0)
    else $error("empty get not reported");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    cmd.ready |-> !ram_we)
    else $error("heap written while idle");
`endif

endmodule

`default_nettype wire
